@@ design/abdc_pkg.sv @@
// ---------------------------------------------------------------------------
// Audio DMA buffer cache package
// Shared types, codes and constants for the buffer cache block.
// ---------------------------------------------------------------------------
`default_nettype none

package abdc_pkg;

   // Number of cache buffers in the pool by default.
   localparam int NUM_SLOTS_DEF = 48;

   // Links between buffers carry a buffer index or the empty marker.
   localparam int LINK_W = 7;
   typedef logic [LINK_W-1:0] link_type;
   localparam link_type LINK_NIL = 7'h7F;

   // Configuration register port.
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_BUF_LEN = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BYPASS  = 2'd1;

   localparam logic [15:0] BUF_LEN_RESET = 16'd1024;

   typedef enum logic {
      CMD_LOOKUP = 1'b0,
      CMD_TICK   = 1'b1
   } cmd_type;

   typedef enum logic [2:0] {
      RSP_HIT     = 3'd0,
      RSP_MISS    = 3'd1,
      RSP_NO_FREE = 3'd2,
      RSP_BYPASS  = 3'd3,
      RSP_FRAME   = 3'd4
   } status_type;

   typedef struct packed {
      cmd_type     command;
      logic [31:0] address;
      logic [15:0] length;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [5:0]  slot;
      logic [15:0] offset;
      logic [31:0] fetch_address;
      logic [5:0]  freed_count;
   } rsp_type;

   // Operation of the shared compare unit.
   typedef enum logic {
      ALU_RANGE = 1'b0,
      ALU_AGE   = 1'b1
   } alu_op_type;

   typedef struct packed {
      logic above;   // stored start lies above the request address
      logic covers;  // buffer end reaches the end of the requested range
      logic stale;   // buffer unused for more than one frame
   } alu_flags_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_WALK_RD,
      ST_WALK_CHK,
      ST_MISS_RD,
      ST_MISS_WR,
      ST_MISS_LINK,
      ST_TICK_RD,
      ST_TICK_CHK,
      ST_TICK_LINK,
      ST_TICK_DONE
   } state_type;

endpackage

`default_nettype wire

@@ design/audio_dma_buffer_cache_unit.sv @@
// ---------------------------------------------------------------------------
// Audio DMA buffer cache unit
// Pool of fixed-length sample buffers caching ROM regions, with frame aging.
// ---------------------------------------------------------------------------
// A request is taken when start is high and busy is low; busy then stays high
// until the request is finished. Every request gives exactly one response on
// rsp_data, marked by rsp_valid for a single cycle, and the receiver cannot
// stall it, so it must capture the response in that cycle. A bypass lookup
// answers in the cycle after it is taken and leaves busy low. Any other
// lookup walks the in-use buffers in ascending start order, a read and a
// check state per buffer visited, and one more read state on running off
// the end of the list. A miss then allocates through the miss read, miss
// write and link states; if the free list is empty the lookup ends in the
// miss read state. A frame tick takes a read and a check state per in-use
// buffer, a link state per buffer freed while the free list is not empty,
// and a final read and done state. For all but a bypass lookup, the
// response is on rsp_data in the first cycle with busy low, and a new
// request can be taken in that same cycle. The single read port of each
// buffer table memory and the one shared compare unit set these steps.
// Configuration writes are always accepted (csr_ready is tied high) and must
// only be issued while the block is idle. No clearing pass runs after reset:
// the free-list links reset through one valid bit per buffer.
// ---------------------------------------------------------------------------
`default_nettype none

module audio_dma_buffer_cache_unit #(
   parameter int NUM_SLOTS = abdc_pkg::NUM_SLOTS_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // request channel
   input  wire logic                           start,
   output logic                                busy,
   input  wire abdc_pkg::req_type              req_data,
   // response channel
   output logic                                rsp_valid,
   output abdc_pkg::rsp_type                   rsp_data,
   // configuration write channel
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [abdc_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [abdc_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int GRD_W  = $clog2(NUM_SLOTS + 1);
   localparam abdc_pkg::link_type NUM_LINK = abdc_pkg::link_type'(NUM_SLOTS);
   localparam logic [GRD_W-1:0]   GRD_MAX  = GRD_W'(NUM_SLOTS);

   // -----------------------------------------------------------------------
   // Registers
   // -----------------------------------------------------------------------
   abdc_pkg::state_type state_ff, state_in;
   abdc_pkg::req_type   req_ff, req_in;
   logic [32:0]         need_ff, need_in;        // address + length, no wrap
   abdc_pkg::link_type  cur_ff, cur_in;          // buffer under inspection
   abdc_pkg::link_type  last_ff, last_in;        // previous kept buffer
   abdc_pkg::link_type  victim_ff, victim_in;    // buffer being allocated/freed
   logic [GRD_W-1:0]    guard_ff, guard_in;
   logic [5:0]          freed_ff, freed_in;
   abdc_pkg::link_type  used_head_ff, used_head_in;
   abdc_pkg::link_type  free_head_ff, free_head_in;
   logic [31:0]         frame_ff, frame_in;
   logic [15:0]         buf_len_ff, buf_len_in;
   logic                bypass_ff, bypass_in;
   logic [NUM_SLOTS-1:0] fvalid_ff, fvalid_in;   // free link written since reset
   logic [SLOT_W-1:0]   fn_raddr_ff;
   logic                fn_rvalid_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   abdc_pkg::rsp_type   rsp_ff, rsp_in;

   // -----------------------------------------------------------------------
   // Buffer table memories
   // -----------------------------------------------------------------------
   logic                st_we, lf_we, un_we, fn_we;
   logic [SLOT_W-1:0]   st_waddr, lf_waddr, un_waddr, fn_waddr;
   logic [31:0]         st_wdata, lf_wdata;
   abdc_pkg::link_type  un_wdata, fn_wdata;
   logic [SLOT_W-1:0]   st_raddr, lf_raddr, un_raddr, fn_raddr;
   logic [31:0]         st_rdata, lf_rdata;
   abdc_pkg::link_type  un_rdata, fn_rdata;

   // Buffer start addresses.
   abdc_ram #(.WIDTH(32), .DEPTH(NUM_SLOTS)) u_start_ram (
      .clock(clock), .wr_en(st_we), .wr_addr(st_waddr), .wr_data(st_wdata),
      .rd_addr(st_raddr), .rd_data(st_rdata)
   );

   // Frame in which each buffer was last used.
   abdc_ram #(.WIDTH(32), .DEPTH(NUM_SLOTS)) u_frame_ram (
      .clock(clock), .wr_en(lf_we), .wr_addr(lf_waddr), .wr_data(lf_wdata),
      .rd_addr(lf_raddr), .rd_data(lf_rdata)
   );

   // In-use list links, sorted by start address.
   abdc_ram #(.WIDTH(abdc_pkg::LINK_W), .DEPTH(NUM_SLOTS)) u_used_ram (
      .clock(clock), .wr_en(un_we), .wr_addr(un_waddr), .wr_data(un_wdata),
      .rd_addr(un_raddr), .rd_data(un_rdata)
   );

   // Free list links.
   abdc_ram #(.WIDTH(abdc_pkg::LINK_W), .DEPTH(NUM_SLOTS)) u_free_ram (
      .clock(clock), .wr_en(fn_we), .wr_addr(fn_waddr), .wr_data(fn_wdata),
      .rd_addr(fn_raddr), .rd_data(fn_rdata)
   );

   // A free link that was never written reads as its reset value: the next
   // buffer, or the empty marker for the last one.
   abdc_pkg::link_type fn_next_idx;
   abdc_pkg::link_type fn_value;

   always_comb begin
      fn_next_idx = abdc_pkg::link_type'(fn_raddr_ff) + abdc_pkg::link_type'(1);
      if (fn_rvalid_ff) begin
         fn_value = fn_rdata;
      end else if (fn_next_idx < NUM_LINK) begin
         fn_value = fn_next_idx;
      end else begin
         fn_value = abdc_pkg::LINK_NIL;
      end
   end

   // -----------------------------------------------------------------------
   // Shared compare unit
   // -----------------------------------------------------------------------
   abdc_pkg::alu_op_type    alu_op;
   abdc_pkg::alu_flags_type alu_flags;

   abdc_alu u_alu (
      .op(alu_op),
      .mem_word((alu_op == abdc_pkg::ALU_RANGE) ? st_rdata : lf_rdata),
      .address(req_ff.address),
      .need(need_ff),
      .buf_len(buf_len_ff),
      .frame(frame_ff),
      .flags(alu_flags)
   );

   // -----------------------------------------------------------------------
   // Sequencer
   // -----------------------------------------------------------------------
   logic cur_ok, last_ok, free_ok, walk_end;

   always_comb begin
      cur_ok   = cur_ff < NUM_LINK;
      last_ok  = last_ff < NUM_LINK;
      free_ok  = free_head_ff < NUM_LINK;
      walk_end = !cur_ok || (guard_ff == GRD_MAX);
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      need_in      = need_ff;
      cur_in       = cur_ff;
      last_in      = last_ff;
      victim_in    = victim_ff;
      guard_in     = guard_ff;
      freed_in     = freed_ff;
      used_head_in = used_head_ff;
      free_head_in = free_head_ff;
      frame_in     = frame_ff;
      buf_len_in   = buf_len_ff;
      bypass_in    = bypass_ff;
      fvalid_in    = fvalid_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;

      alu_op   = abdc_pkg::ALU_RANGE;
      st_we    = 1'b0;
      lf_we    = 1'b0;
      un_we    = 1'b0;
      fn_we    = 1'b0;
      st_waddr = free_head_ff[SLOT_W-1:0];
      lf_waddr = cur_ff[SLOT_W-1:0];
      un_waddr = free_head_ff[SLOT_W-1:0];
      fn_waddr = cur_ff[SLOT_W-1:0];
      st_wdata = {req_ff.address[31:1], 1'b0};
      lf_wdata = frame_ff;
      un_wdata = last_ok ? un_rdata : used_head_ff;
      fn_wdata = abdc_pkg::LINK_NIL;
      st_raddr = cur_ff[SLOT_W-1:0];
      lf_raddr = cur_ff[SLOT_W-1:0];
      un_raddr = cur_ff[SLOT_W-1:0];
      fn_raddr = free_head_ff[SLOT_W-1:0];

      if (csr_valid && csr_ready) begin
         case (csr_index)
            abdc_pkg::CSR_BUF_LEN: buf_len_in = csr_wdata;
            abdc_pkg::CSR_BYPASS:  bypass_in  = csr_wdata[0];
            default: ;
         endcase
      end

      case (state_ff)
         abdc_pkg::ST_IDLE: begin
            if (start) begin
               req_in   = req_data;
               need_in  = {1'b0, req_data.address} + {17'd0, req_data.length};
               cur_in   = used_head_ff;
               last_in  = abdc_pkg::LINK_NIL;
               guard_in = '0;
               freed_in = '0;
               if (req_data.command == abdc_pkg::CMD_TICK) begin
                  state_in = abdc_pkg::ST_TICK_RD;
               end else if (bypass_ff) begin
                  rsp_valid_in         = 1'b1;
                  rsp_in               = '0;
                  rsp_in.status        = abdc_pkg::RSP_BYPASS;
                  rsp_in.fetch_address = req_data.address;
               end else begin
                  state_in = abdc_pkg::ST_WALK_RD;
               end
            end
         end

         abdc_pkg::ST_WALK_RD: begin
            // Read start and link of the current buffer.
            state_in = walk_end ? abdc_pkg::ST_MISS_RD : abdc_pkg::ST_WALK_CHK;
         end

         abdc_pkg::ST_WALK_CHK: begin
            alu_op = abdc_pkg::ALU_RANGE;
            if (alu_flags.above) begin
               state_in = abdc_pkg::ST_MISS_RD;
            end else if (alu_flags.covers) begin
               lf_we         = 1'b1;
               rsp_valid_in  = 1'b1;
               rsp_in        = '0;
               rsp_in.status = abdc_pkg::RSP_HIT;
               rsp_in.slot   = 6'(cur_ff[SLOT_W-1:0]);
               rsp_in.offset = 16'(req_ff.address - st_rdata);
               state_in      = abdc_pkg::ST_IDLE;
            end else begin
               last_in  = cur_ff;
               cur_in   = un_rdata;
               guard_in = guard_ff + GRD_W'(1);
               state_in = abdc_pkg::ST_WALK_RD;
            end
         end

         abdc_pkg::ST_MISS_RD: begin
            un_raddr = last_ff[SLOT_W-1:0];
            if (!free_ok) begin
               rsp_valid_in  = 1'b1;
               rsp_in        = '0;
               rsp_in.status = abdc_pkg::RSP_NO_FREE;
               state_in      = abdc_pkg::ST_IDLE;
            end else begin
               state_in = abdc_pkg::ST_MISS_WR;
            end
         end

         abdc_pkg::ST_MISS_WR: begin
            // Take the free head: unlink it and fill in its table entries.
            free_head_in = fn_value;
            fn_we        = 1'b1;
            fn_waddr     = free_head_ff[SLOT_W-1:0];
            fn_wdata     = abdc_pkg::LINK_NIL;
            fvalid_in[free_head_ff[SLOT_W-1:0]] = 1'b1;
            un_we        = 1'b1;
            st_we        = 1'b1;
            lf_we        = 1'b1;
            lf_waddr     = free_head_ff[SLOT_W-1:0];
            victim_in    = free_head_ff;
            state_in     = abdc_pkg::ST_MISS_LINK;
         end

         abdc_pkg::ST_MISS_LINK: begin
            if (last_ok) begin
               un_we    = 1'b1;
               un_waddr = last_ff[SLOT_W-1:0];
               un_wdata = victim_ff;
            end else begin
               used_head_in = victim_ff;
            end
            rsp_valid_in         = 1'b1;
            rsp_in               = '0;
            rsp_in.status        = abdc_pkg::RSP_MISS;
            rsp_in.slot          = 6'(victim_ff[SLOT_W-1:0]);
            rsp_in.offset        = {15'd0, req_ff.address[0]};
            rsp_in.fetch_address = {req_ff.address[31:1], 1'b0};
            state_in             = abdc_pkg::ST_IDLE;
         end

         abdc_pkg::ST_TICK_RD: begin
            // Read link and frame stamp of the current buffer, and the link
            // after the free head in case this buffer is released.
            state_in = walk_end ? abdc_pkg::ST_TICK_DONE : abdc_pkg::ST_TICK_CHK;
         end

         abdc_pkg::ST_TICK_CHK: begin
            alu_op   = abdc_pkg::ALU_AGE;
            cur_in   = un_rdata;
            guard_in = guard_ff + GRD_W'(1);
            state_in = abdc_pkg::ST_TICK_RD;
            if (alu_flags.stale) begin
               if (last_ok) begin
                  un_we    = 1'b1;
                  un_waddr = last_ff[SLOT_W-1:0];
                  un_wdata = un_rdata;
               end else begin
                  used_head_in = un_rdata;
               end
               fn_we    = 1'b1;
               fn_waddr = cur_ff[SLOT_W-1:0];
               fvalid_in[cur_ff[SLOT_W-1:0]] = 1'b1;
               if (free_ok) begin
                  fn_wdata  = fn_value;
                  victim_in = cur_ff;
                  state_in  = abdc_pkg::ST_TICK_LINK;
               end else begin
                  fn_wdata     = abdc_pkg::LINK_NIL;
                  free_head_in = cur_ff;
               end
               freed_in = freed_ff + 6'd1;
            end else begin
               last_in = cur_ff;
            end
         end

         abdc_pkg::ST_TICK_LINK: begin
            // The released buffer goes right after the free head.
            fn_we    = 1'b1;
            fn_waddr = free_head_ff[SLOT_W-1:0];
            fn_wdata = victim_ff;
            fvalid_in[free_head_ff[SLOT_W-1:0]] = 1'b1;
            state_in = abdc_pkg::ST_TICK_RD;
         end

         abdc_pkg::ST_TICK_DONE: begin
            frame_in           = frame_ff + 32'd1;
            rsp_valid_in       = 1'b1;
            rsp_in             = '0;
            rsp_in.status      = abdc_pkg::RSP_FRAME;
            rsp_in.freed_count = freed_ff;
            state_in           = abdc_pkg::ST_IDLE;
         end

         default: begin
            state_in = abdc_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= abdc_pkg::ST_IDLE;
         used_head_ff <= abdc_pkg::LINK_NIL;
         free_head_ff <= '0;
         frame_ff     <= '0;
         buf_len_ff   <= abdc_pkg::BUF_LEN_RESET;
         bypass_ff    <= 1'b0;
         fvalid_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_head_ff <= used_head_in;
         free_head_ff <= free_head_in;
         frame_ff     <= frame_in;
         buf_len_ff   <= buf_len_in;
         bypass_ff    <= bypass_in;
         fvalid_ff    <= fvalid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      need_ff      <= need_in;
      cur_ff       <= cur_in;
      last_ff      <= last_in;
      victim_ff    <= victim_in;
      guard_ff     <= guard_in;
      freed_ff     <= freed_in;
      rsp_ff       <= rsp_in;
      fn_raddr_ff  <= fn_raddr;
      fn_rvalid_ff <= fvalid_ff[fn_raddr];
   end

   assign busy      = state_ff != abdc_pkg::ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

   // -----------------------------------------------------------------------
   // Assertions
   // -----------------------------------------------------------------------

   // A response is only issued while the sequencer is idle.
   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response issued while the sequencer is still busy");

   // A frame tick always occupies the sequencer.
   a_tick_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_data.command == abdc_pkg::CMD_TICK)) |=> busy)
      else $error("frame tick accepted without the sequencer going busy");

   // The free head is always a buffer index or the empty marker.
   a_free_head: assert property (@(posedge clock) disable iff (reset)
      (free_head_ff < NUM_LINK) || (free_head_ff == abdc_pkg::LINK_NIL))
      else $error("free list head holds an invalid link");

   // A frame-done response coincides with the frame count stepping by one.
   a_frame_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status == abdc_pkg::RSP_FRAME))
         |-> (frame_ff == $past(frame_ff) + 32'd1))
      else $error("frame count did not advance with the frame tick");

endmodule

`default_nettype wire

@@ design/abdc_ram.sv @@
// ---------------------------------------------------------------------------
// Buffer cache RAM
// Generic single write port, single read port memory with registered read.
// ---------------------------------------------------------------------------
`default_nettype none

module abdc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                   clock,
   input  wire logic                   wr_en,
   input  wire logic [AW-1:0]          wr_addr,
   input  wire logic [WIDTH-1:0]       wr_data,
   input  wire logic [AW-1:0]          rd_addr,
   output logic      [WIDTH-1:0]       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

@@ design/abdc_alu.sv @@
// ---------------------------------------------------------------------------
// Buffer cache compare unit
// Shared adder and comparators used by both the lookup walk and frame aging.
// ---------------------------------------------------------------------------
`default_nettype none

module abdc_alu (
   input  wire abdc_pkg::alu_op_type op,
   input  wire logic [31:0]          mem_word,
   input  wire logic [31:0]          address,
   input  wire logic [32:0]          need,
   input  wire logic [15:0]          buf_len,
   input  wire logic [31:0]          frame,
   output abdc_pkg::alu_flags_type   flags
);

   logic [31:0] addend;
   logic [32:0] sum;

   // Range check adds the buffer length to the start, aging adds one frame.
   always_comb begin
      addend = (op == abdc_pkg::ALU_RANGE) ? {16'd0, buf_len} : 32'd1;
      sum    = {1'b0, mem_word} + {1'b0, addend};
      flags.above  = mem_word > address;
      flags.covers = need <= sum;
      flags.stale  = sum[31:0] < frame;
   end

endmodule

`default_nettype wire
